// File: design/bde_pkg.sv
// bde_pkg: shared types and constants of the BRIEF descriptor engine.
// Used by the front, queue, back and top level; no dependencies.
`timescale 1ns / 1ps

package bde_pkg;

  localparam int unsigned PATCH_SIZE_DEF = 31;
  localparam int unsigned NUM_PAIRS_DEF  = 256;
  localparam int unsigned PAIRS_PER_BYTE = 8;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned S_DATA_W       = 48;
  localparam int unsigned S_USER_W       = 2;
  localparam int unsigned M_DATA_W       = 16;
  localparam int unsigned ENTRY_W        = 20;

  typedef enum logic [1:0] {
    ACT_PAIR    = 2'd0,
    ACT_PIXEL   = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_DRAIN
  } back_state_e;

  // One queued request; pair_entry holds the four offsets, first row lowest.
  typedef struct packed {
    action_e             kind;
    logic [7:0]          pair_index;
    logic [ENTRY_W-1:0]  pair_entry;
    logic [4:0]          pixel_row;
    logic [4:0]          pixel_col;
    logic [7:0]          pixel_value;
  } cmd_t;

endpackage

// File: design/bde_front.sv
// bde_front: accepts input requests, unpacks the fields and drops those
// that have no effect. Depends on bde_pkg.
`timescale 1ns / 1ps

module bde_front
  import bde_pkg::*;
#(
  parameter int unsigned PATCH_SIZE = PATCH_SIZE_DEF,
  parameter int unsigned NUM_PAIRS  = NUM_PAIRS_DEF
) (
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [S_DATA_W-1:0] s_tdata_i,
  input  logic [S_USER_W-1:0] s_tuser_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output cmd_t                q_cmd_o
);

  logic accept;
  logic keep;

  assign s_tready_o = !q_full_i;
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    q_cmd_o.kind        = action_e'(s_tuser_i);
    q_cmd_o.pair_index  = s_tdata_i[7:0];
    q_cmd_o.pair_entry  = s_tdata_i[27:8];
    q_cmd_o.pixel_row   = s_tdata_i[32:28];
    q_cmd_o.pixel_col   = s_tdata_i[37:33];
    q_cmd_o.pixel_value = s_tdata_i[45:38];
  end

  // Out-of-range loads and the unused action code are swallowed here.
  always_comb begin
    case (action_e'(s_tuser_i))
      ACT_PAIR:    keep = 32'(s_tdata_i[7:0]) < NUM_PAIRS;
      ACT_PIXEL:   keep = (32'(s_tdata_i[32:28]) < PATCH_SIZE)
                       && (32'(s_tdata_i[37:33]) < PATCH_SIZE);
      ACT_COMPUTE: keep = 1'b1;
      default:     keep = 1'b0;
    endcase
  end

  assign q_push_o = accept && keep;

endmodule

// File: design/bde_queue.sv
// bde_queue: short request queue between the front and the back.
// Depends on bde_pkg.
`timescale 1ns / 1ps

module bde_queue
  import bde_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  cmd_t            slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            do_pop;

  assign full_o  = count_q == (PtrW + 1)'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (PtrW + 1)'(push_i) - (PtrW + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: design/bde_back.sv
// bde_back: pair table and patch store, the comparison pipeline and the
// output register. Depends on bde_pkg.
`timescale 1ns / 1ps

module bde_back
  import bde_pkg::*;
#(
  parameter int unsigned PATCH_SIZE = PATCH_SIZE_DEF,
  parameter int unsigned NUM_PAIRS  = NUM_PAIRS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  cmd_t                q_cmd_i,
  output logic                q_pop_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [M_DATA_W-1:0] m_tdata_o,
  output logic                m_tlast_o
);

  localparam int unsigned KW       = $clog2(NUM_PAIRS);
  localparam int unsigned CW       = $clog2(PATCH_SIZE);
  localparam int unsigned PA       = $clog2(PATCH_SIZE * PATCH_SIZE);
  localparam int unsigned NumBytes = NUM_PAIRS / PAIRS_PER_BYTE;
  localparam int unsigned NumUsed  = NumBytes * PAIRS_PER_BYTE;
  localparam int unsigned Centre   = PATCH_SIZE / 2;
  localparam logic [KW-1:0] LastK  = KW'(NumUsed - 1);

  function automatic logic [CW-1:0] clamp_coord(input logic [4:0] off);
    logic signed [7:0] p;
    p = signed'({{3{off[4]}}, off}) + signed'(8'(Centre));
    if (p < 8'sd0) begin
      clamp_coord = '0;
    end else if (p > signed'(8'(PATCH_SIZE - 1))) begin
      clamp_coord = CW'(PATCH_SIZE - 1);
    end else begin
      clamp_coord = CW'(p);
    end
  endfunction

  function automatic logic [PA-1:0] pix_addr(input logic [CW-1:0] r,
                                              input logic [CW-1:0] c);
    pix_addr = PA'(PA'(r) * PA'(PATCH_SIZE) + PA'(c));
  endfunction

  logic [ENTRY_W-1:0] pair_mem  [NUM_PAIRS];
  logic [7:0]         patch_mem [PATCH_SIZE * PATCH_SIZE];

  back_state_e        state_q, state_d;
  logic [KW-1:0]      k_q, k_d;
  logic               adv;
  logic               issue;
  logic               pair_we, pix_we;
  logic [PA-1:0]      pix_waddr, addr_a, addr_b;

  logic               v1_q, v2_q;
  logic [KW-1:0]      k1_q, k2_q;
  logic [ENTRY_W-1:0] pair_rd_q;
  logic [7:0]         pix_a_q, pix_b_q;
  logic [7:0]         acc_q, byte_d;
  logic [2:0]         bit_pos;
  logic               byte_done;

  logic               out_valid_q;
  logic [4:0]         out_idx_q;
  logic [7:0]         out_byte_q;
  logic               out_last_q;

  // The whole pipeline holds while a finished byte waits downstream.
  assign adv   = !out_valid_q || m_tready_i;
  assign issue = (state_q == BK_ISSUE) && adv;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    q_pop_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.kind == ACT_COMPUTE) begin
            state_d = BK_ISSUE;
            k_d     = '0;
          end
        end
      end
      BK_ISSUE: begin
        if (adv) begin
          k_d = k_q + 1'b1;
          if (k_q == LastK) begin
            state_d = BK_DRAIN;
          end
        end
      end
      BK_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  assign pair_we   = q_pop_o && (q_cmd_i.kind == ACT_PAIR);
  assign pix_we    = q_pop_o && (q_cmd_i.kind == ACT_PIXEL);
  assign pix_waddr = pix_addr(CW'(q_cmd_i.pixel_row), CW'(q_cmd_i.pixel_col));
  // Row offset picks the patch row, column offset the column.
  assign addr_a = pix_addr(clamp_coord(pair_rd_q[4:0]), clamp_coord(pair_rd_q[9:5]));
  assign addr_b = pix_addr(clamp_coord(pair_rd_q[14:10]), clamp_coord(pair_rd_q[19:15]));

  always_ff @(posedge clk_i) begin
    if (pair_we) begin
      pair_mem[KW'(q_cmd_i.pair_index)] <= q_cmd_i.pair_entry;
    end
    if (issue) begin
      pair_rd_q <= pair_mem[k_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      patch_mem[pix_waddr] <= q_cmd_i.pixel_value;
    end
    if (adv && v1_q) begin
      pix_a_q <= patch_mem[addr_a];
      pix_b_q <= patch_mem[addr_b];
    end
  end

  assign bit_pos   = k2_q[2:0];
  assign byte_d    = ((bit_pos == 3'd0) ? 8'h00 : acc_q)
                   | (8'(pix_a_q < pix_b_q) << bit_pos);
  assign byte_done = v2_q && (bit_pos == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        v1_q <= issue;
        v2_q <= v1_q;
      end
      if (adv && byte_done) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k1_q <= k_q;
      k2_q <= k1_q;
      if (v2_q) begin
        acc_q <= byte_d;
      end
      if (byte_done) begin
        out_byte_q <= byte_d;
        out_idx_q  <= 5'(k2_q >> 3);
        out_last_q <= k2_q == LastK;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = M_DATA_W'({out_byte_q, out_idx_q});
  assign m_tlast_o  = out_last_q;

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_IDLE |-> !v1_q && !v2_q)
    else $error("pipeline busy while back end idle");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_idx_q == 5'(NumBytes - 1))
    else $error("last byte flagged at wrong index");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_tready_i |=> $stable(k_q) && $stable(v1_q) && $stable(v2_q))
    else $error("pipeline moved during output stall");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != BK_IDLE |-> !pair_we && !pix_we)
    else $error("store written during compute");

endmodule

// File: design/brief_descriptor_engine.sv
// brief_descriptor_engine: top level, 256-bit BRIEF descriptor of a grey patch.
// Instantiates bde_front, bde_queue and bde_back; depends on bde_pkg.
//
//   Channel  Dir  tdata (low bit first)                                tuser / tlast
//   s_*      in   pair_index 8, first_row_offset 5, first_col_offset 5,  tuser: action 2
//                 second_row_offset 5, second_col_offset 5, pixel_row 5,
//                 pixel_col 5, pixel_value 8, zero pad 2
//   m_*      out  byte_index 5, descriptor_byte 8, zero pad 3          tlast: last_byte
//
// Pair and pixel loads drain through the queue at one per cycle while no compute runs.
// A compute runs one pair per cycle, unless the output stalls, through the
// pair table read, the two-port patch read and the compare; eight pairs fill a byte.
// A byte stalled on the output holds the whole compare pipeline.
// Reset clears control only; the pair table and patch store are not cleared.
`timescale 1ns / 1ps

module brief_descriptor_engine
  import bde_pkg::*;
#(
  parameter int unsigned PATCH_SIZE = PATCH_SIZE_DEF,
  parameter int unsigned NUM_PAIRS  = NUM_PAIRS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  // pair_index, first_row, first_col, second_row, second_col, pixel_row,
  // pixel_col, pixel_value
  input  logic [S_DATA_W-1:0] s_tdata_i,
  // action
  input  logic [S_USER_W-1:0] s_tuser_i,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  // byte_index, descriptor_byte
  output logic [M_DATA_W-1:0] m_tdata_o,
  output logic                m_tlast_o
);

  logic q_push, q_full, q_valid, q_pop;
  cmd_t q_in, q_out;

  bde_front #(
    .PATCH_SIZE (PATCH_SIZE),
    .NUM_PAIRS  (NUM_PAIRS)
  ) u_front (
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_in)
  );

  bde_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (q_out)
  );

  bde_back #(
    .PATCH_SIZE (PATCH_SIZE),
    .NUM_PAIRS  (NUM_PAIRS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_out),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

endmodule
